// ===== sv/xxh64_pkg.sv =====
// ============================================================================
// xxh64_pkg: shared constants, types and helpers for the XXH64 hasher
// Primes, micro-operation codes and the command/status structs that join
// the controller to the datapath.
// ============================================================================
`default_nettype none

package xxh64_pkg;

   // XXH64 primes
   localparam logic [63:0] PRIME1 = 64'h9e3779b185ebca87;
   localparam logic [63:0] PRIME2 = 64'hc2b2ae3d27d4eb4f;
   localparam logic [63:0] PRIME3 = 64'h165667b19e3779f9;
   localparam logic [63:0] PRIME4 = 64'h85ebca77c2b2ae63;
   localparam logic [63:0] PRIME5 = 64'h27d4eb2f165667c5;

   // bytes in one full message word
   localparam logic [3:0]  WORD_BYTES = 4'd8;

   // multiplier operand selection
   typedef enum logic [3:0] {
      A_SRC,      // buffered word, or the current word for index three
      A_LANE,     // lane accumulator at index
      A_ROT31K,   // rotl(k, 31)
      A_ROT27H,   // rotl(h, 27)
      A_ROT23H,   // rotl(h, 23)
      A_ROT11H,   // rotl(h, 11)
      A_H,        // h as is
      A_WORD32,   // low half of the current word
      A_BYTE,     // byte of the current word at index
      A_AV33,     // h ^ (h >> 33)
      A_AV29      // h ^ (h >> 29)
   } opa_type;

   // multiplier constant selection
   typedef enum logic [1:0] {
      K_P1,
      K_P2,
      K_P3,
      K_P5
   } ksel_type;

   // where the product goes
   typedef enum logic [2:0] {
      W_KLANE,    // k = lane[idx] + p
      W_KSET,     // k = p
      W_LANE,     // lane[idx] = p
      W_HXOR,     // h ^= p
      W_HP4,      // h = p + prime4
      W_HP3,      // h = p + prime3
      W_HSET      // h = p
   } post_type;

   // controller to datapath
   typedef struct packed {
      logic       accept;       // capture the input word
      logic       issue;        // start a multiply
      logic       write;        // retire a multiply
      opa_type    opa;
      ksel_type   ksel;
      post_type   post;
      logic [2:0] idx;          // lane, buffer or byte index
      logic       stripe_done;  // stripe retired
      logic       hrot;         // h = (idx ? h : 0) + rotl(lane[idx])
      logic       short_key;    // h = lane2 + prime5
      logic       add_len;      // h += length
      logic       emit;         // finalise and load the result register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       in_last;      // incoming word is the last one
      logic       in_full;      // incoming byte count is eight or more
      logic [1:0] pos;          // words held in the stripe buffer
      logic [3:0] cnt;          // tail byte count of the last word
      logic       seen;         // a stripe has been processed
      logic       last;         // the word held is the last one
   } dp_status_type;

   function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
      rotl64 = (v << r) | (v >> (64 - r));
   endfunction

   function automatic logic [63:0] prime_of(input ksel_type k);
      logic [63:0] p;
      case (k)
         K_P1:    p = PRIME1;
         K_P2:    p = PRIME2;
         K_P3:    p = PRIME3;
         K_P5:    p = PRIME5;
         default: p = PRIME1;
      endcase
      prime_of = p;
   endfunction

endpackage

`default_nettype wire

// ===== sv/xxh64_if.sv =====
// ============================================================================
// xxh64_if: channel interfaces of the XXH64 hasher
// Message word channel, hash result channel and seed write channel, each
// with valid/ready and its payload.
// ============================================================================
`default_nettype none

interface xxh64_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [3:0]  byte_count;
   logic        last;

   modport source (output valid, output data_word, output byte_count, output last,
                   input ready);
   modport sink   (input valid, input data_word, input byte_count, input last,
                   output ready);
endinterface

interface xxh64_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

interface xxh64_csr_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_seed;

   modport source (output valid, output hash_seed, input ready);
   modport sink   (input valid, input hash_seed, output ready);
endinterface

`default_nettype wire

// ===== sv/xxh64_mul.sv =====
// ============================================================================
// xxh64_mul: two-stage 64x64 multiplier, low 64 bits of the product
// Stage one forms three 32x32 partial products, stage two sums them.
// ============================================================================
`default_nettype none

module xxh64_mul (
   input  logic                clock,
   input  logic                issue,
   input  logic [63:0]         op_a,
   input  xxh64_pkg::ksel_type ksel,
   output logic [63:0]         product
);
   import xxh64_pkg::*;

   logic [63:0] op_b;
   logic [63:0] pp_ll_in, pp_ll_ff;
   logic [31:0] pp_lh_in, pp_lh_ff;
   logic [31:0] pp_hl_in, pp_hl_ff;

   // partial products; cross terms only need their low halves
   assign op_b     = prime_of(ksel);
   assign pp_ll_in = op_a[31:0] * op_b[31:0];
   assign pp_lh_in = op_a[31:0] * op_b[63:32];
   assign pp_hl_in = op_a[63:32] * op_b[31:0];

   always_ff @(posedge clock) begin
      if (issue) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
      end
   end

   // recombine
   assign product = pp_ll_ff + {pp_lh_ff + pp_hl_ff, 32'd0};

endmodule

`default_nettype wire

// ===== sv/xxh64_datapath.sv =====
// ============================================================================
// xxh64_datapath: XXH64 state, operand selection and result register
// Holds seed, lanes, stripe buffer, length and the running hash; executes
// the controller's commands through the shared multiplier.
// ============================================================================
`default_nettype none

module xxh64_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  xxh64_pkg::dp_cmd_type    cmd,
   output xxh64_pkg::dp_status_type status,
   input  logic [63:0]              in_data_word,
   input  logic [3:0]               in_byte_count,
   input  logic                     in_last,
   input  logic                     seed_we,
   input  logic [63:0]              seed_data,
   output logic [63:0]              hash_value
);
   import xxh64_pkg::*;

   logic [63:0] seed_ff, seed_in;
   logic [63:0] lane_ff [4];
   logic [63:0] lane_in [4];
   logic [63:0] buf_ff  [3];
   logic [63:0] buf_in  [3];
   logic [63:0] word_ff, word_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic [1:0]  pos_ff, pos_in;
   logic [63:0] len_ff, len_in;
   logic        seen_ff, seen_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] k_ff, k_in;
   logic [63:0] hash_ff, hash_in;

   logic [3:0]  cnt_clamp;
   logic        fresh;
   logic [63:0] src_word;
   logic [63:0] op_a;
   logic [63:0] product;
   logic [63:0] rot_lane;

   assign cnt_clamp = (in_byte_count > WORD_BYTES) ? WORD_BYTES : in_byte_count;
   assign fresh     = (pos_ff == 2'd0) && (len_ff == 64'd0) && !seen_ff;
   assign src_word  = (cmd.idx[1:0] == 2'd3) ? word_ff : buf_ff[cmd.idx[1:0]];

   // multiplier operand
   always_comb begin
      case (cmd.opa)
         A_SRC:    op_a = src_word;
         A_LANE:   op_a = lane_ff[cmd.idx[1:0]];
         A_ROT31K: op_a = rotl64(k_ff, 31);
         A_ROT27H: op_a = rotl64(h_ff, 27);
         A_ROT23H: op_a = rotl64(h_ff, 23);
         A_ROT11H: op_a = rotl64(h_ff, 11);
         A_H:      op_a = h_ff;
         A_WORD32: op_a = {32'd0, word_ff[31:0]};
         A_BYTE:   op_a = {56'd0, word_ff[{cmd.idx, 3'b000} +: 8]};
         A_AV33:   op_a = h_ff ^ (h_ff >> 33);
         A_AV29:   op_a = h_ff ^ (h_ff >> 29);
         default:  op_a = h_ff;
      endcase
   end

   xxh64_mul u_mul (
      .clock   (clock),
      .issue   (cmd.issue),
      .op_a    (op_a),
      .ksel    (cmd.ksel),
      .product (product)
   );

   // lane merge rotations
   always_comb begin
      case (cmd.idx[1:0])
         2'd0:    rot_lane = rotl64(lane_ff[0], 1);
         2'd1:    rot_lane = rotl64(lane_ff[1], 7);
         2'd2:    rot_lane = rotl64(lane_ff[2], 12);
         default: rot_lane = rotl64(lane_ff[3], 18);
      endcase
   end

   // next state
   always_comb begin
      seed_in = seed_ff;
      lane_in = lane_ff;
      buf_in  = buf_ff;
      word_in = word_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      pos_in  = pos_ff;
      len_in  = len_ff;
      seen_in = seen_ff;
      h_in    = h_ff;
      k_in    = k_ff;
      hash_in = hash_ff;

      if (seed_we) begin
         seed_in = seed_data;
      end

      // word transfer: lanes load at message start, non-last words fill the stripe buffer
      if (cmd.accept) begin
         word_in = in_data_word;
         cnt_in  = cnt_clamp;
         last_in = in_last;
         len_in  = len_ff + (in_last ? {60'd0, cnt_clamp} : {60'd0, WORD_BYTES});
         if (fresh) begin
            lane_in[0] = seed_ff + PRIME1 + PRIME2;
            lane_in[1] = seed_ff + PRIME2;
            lane_in[2] = seed_ff;
            lane_in[3] = seed_ff - PRIME1;
         end
         if (!in_last && pos_ff != 2'd3) begin
            buf_in[pos_ff] = in_data_word;
            pos_in         = pos_ff + 2'd1;
         end
      end

      // retire a multiply
      if (cmd.write) begin
         case (cmd.post)
            W_KLANE: k_in = lane_ff[cmd.idx[1:0]] + product;
            W_KSET:  k_in = product;
            W_LANE:  lane_in[cmd.idx[1:0]] = product;
            W_HXOR:  h_in = h_ff ^ product;
            W_HP4:   h_in = product + PRIME4;
            W_HP3:   h_in = product + PRIME3;
            W_HSET:  h_in = product;
            default: h_in = product;
         endcase
      end

      if (cmd.stripe_done) begin
         pos_in  = 2'd0;
         seen_in = 1'b1;
         cnt_in  = 4'd0;
      end

      if (cmd.hrot) begin
         h_in = ((cmd.idx == 3'd0) ? 64'd0 : h_ff) + rot_lane;
      end
      if (cmd.short_key) begin
         h_in = lane_ff[2] + PRIME5;
      end
      if (cmd.add_len) begin
         h_in = h_ff + len_ff;
      end

      // last avalanche step and message state cleared
      if (cmd.emit) begin
         hash_in = h_ff ^ (h_ff >> 32);
         pos_in  = 2'd0;
         len_in  = 64'd0;
         seen_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 64'd0;
         pos_ff  <= 2'd0;
         len_ff  <= 64'd0;
         seen_ff <= 1'b0;
      end else begin
         seed_ff <= seed_in;
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         seen_ff <= seen_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
      buf_ff  <= buf_in;
      word_ff <= word_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
      h_ff    <= h_in;
      k_ff    <= k_in;
      hash_ff <= hash_in;
   end

   assign status.in_last = in_last;
   assign status.in_full = (in_byte_count >= WORD_BYTES);
   assign status.pos     = pos_ff;
   assign status.cnt     = cnt_ff;
   assign status.seen    = seen_ff;
   assign status.last    = last_ff;
   assign hash_value     = hash_ff;

endmodule

`default_nettype wire

// ===== sv/xxh64_ctrl.sv =====
// ============================================================================
// xxh64_ctrl: sequencer of the XXH64 hasher
// One-hot state machine that steps the datapath through stripe rounds,
// lane merge, tail steps and avalanche, and owns the handshakes.
// ============================================================================
`default_nettype none

module xxh64_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  xxh64_pkg::dp_status_type status,
   output xxh64_pkg::dp_cmd_type    cmd
);
   import xxh64_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b00000000001,
      S_STRIPE   = 11'b00000000010,
      S_MRG_ROT  = 11'b00000000100,
      S_MRG_LANE = 11'b00000001000,
      S_SHORT    = 11'b00000010000,
      S_ADDLEN   = 11'b00000100000,
      S_TAIL8    = 11'b00001000000,
      S_TAIL4    = 11'b00010000000,
      S_TAIL1    = 11'b00100000000,
      S_AVAL     = 11'b01000000000,
      S_EMIT     = 11'b10000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic       wr_ff, wr_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       accept;
   logic       mul_state;
   logic       last_step;
   logic       item_done;
   logic       word_done;
   logic       out_free;
   state_type  after_state;
   logic [2:0] after_idx;
   opa_type    opa;
   ksel_type   ksel;
   post_type   post;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign mul_state = state_ff inside {S_STRIPE, S_MRG_LANE, S_TAIL8, S_TAIL4, S_TAIL1, S_AVAL};
   assign last_step = (state_ff inside {S_MRG_LANE, S_TAIL8}) ? (step_ff == 2'd2)
                                                               : (step_ff == 2'd1);
   assign item_done = mul_state && wr_ff && last_step;
   assign word_done = (state_ff == S_TAIL8) && (idx_ff == 3'd3);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // what follows the length step and the buffered 8-byte steps
   always_comb begin
      after_idx = 3'd0;
      if (status.cnt[3] && !word_done) begin
         after_state = S_TAIL8;
         after_idx   = 3'd3;
      end else if (status.cnt[3]) begin
         after_state = S_AVAL;
      end else if (status.cnt[2]) begin
         after_state = S_TAIL4;
      end else if (status.cnt != 4'd0) begin
         after_state = S_TAIL1;
      end else begin
         after_state = S_AVAL;
      end
   end

   // micro-operation of each multiply step
   always_comb begin
      opa  = A_H;
      ksel = K_P1;
      post = W_HSET;
      case (state_ff)
         S_STRIPE: begin
            if (step_ff == 2'd0) begin
               opa = A_SRC;    ksel = K_P2; post = W_KLANE;
            end else begin
               opa = A_ROT31K; ksel = K_P1; post = W_LANE;
            end
         end
         S_MRG_LANE: begin
            case (step_ff)
               2'd0:    begin opa = A_LANE;   ksel = K_P2; post = W_KSET; end
               2'd1:    begin opa = A_ROT31K; ksel = K_P1; post = W_HXOR; end
               default: begin opa = A_H;      ksel = K_P1; post = W_HP4;  end
            endcase
         end
         S_TAIL8: begin
            case (step_ff)
               2'd0:    begin opa = A_SRC;    ksel = K_P2; post = W_KSET; end
               2'd1:    begin opa = A_ROT31K; ksel = K_P1; post = W_HXOR; end
               default: begin opa = A_ROT27H; ksel = K_P1; post = W_HP4;  end
            endcase
         end
         S_TAIL4: begin
            if (step_ff == 2'd0) begin
               opa = A_WORD32; ksel = K_P1; post = W_HXOR;
            end else begin
               opa = A_ROT23H; ksel = K_P2; post = W_HP3;
            end
         end
         S_TAIL1: begin
            if (step_ff == 2'd0) begin
               opa = A_BYTE;   ksel = K_P5; post = W_HXOR;
            end else begin
               opa = A_ROT11H; ksel = K_P1; post = W_HSET;
            end
         end
         S_AVAL: begin
            if (step_ff == 2'd0) begin
               opa = A_AV33; ksel = K_P2; post = W_HSET;
            end else begin
               opa = A_AV29; ksel = K_P3; post = W_HSET;
            end
         end
         default: begin
            opa = A_H;
         end
      endcase
   end

   // sequencing
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      wr_in    = wr_ff;
      idx_in   = idx_ff;

      cmd       = '0;
      cmd.issue = mul_state && !wr_ff;
      cmd.write = mul_state && wr_ff;
      cmd.opa   = opa;
      cmd.ksel  = ksel;
      cmd.post  = post;
      cmd.idx   = idx_ff;

      // each multiply is an issue step then a write step, tracked by wr_ff
      if (mul_state) begin
         if (!wr_ff) begin
            wr_in = 1'b1;
         end else begin
            wr_in   = 1'b0;
            step_in = last_step ? 2'd0 : step_ff + 2'd1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               idx_in     = 3'd0;
               step_in    = 2'd0;
               if (status.pos == 2'd3 && (!status.in_last || status.in_full)) begin
                  state_in = S_STRIPE;
               end else if (status.in_last) begin
                  state_in = status.seen ? S_MRG_ROT : S_SHORT;
               end
            end
         end
         S_STRIPE: begin
            if (item_done) begin
               if (idx_ff == 3'd3) begin
                  cmd.stripe_done = 1'b1;
                  idx_in          = 3'd0;
                  state_in        = status.last ? S_MRG_ROT : S_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         S_MRG_ROT: begin
            cmd.hrot = 1'b1;
            if (idx_ff == 3'd3) begin
               idx_in   = 3'd0;
               state_in = S_MRG_LANE;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         S_MRG_LANE: begin
            if (item_done) begin
               if (idx_ff == 3'd3) begin
                  state_in = S_ADDLEN;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         S_SHORT: begin
            cmd.short_key = 1'b1;
            state_in      = S_ADDLEN;
         end
         S_ADDLEN: begin
            cmd.add_len = 1'b1;
            if (status.pos != 2'd0) begin
               state_in = S_TAIL8;
               idx_in   = 3'd0;
            end else begin
               state_in = after_state;
               idx_in   = after_idx;
            end
         end
         S_TAIL8: begin
            if (item_done) begin
               if (idx_ff != 3'd3 && (idx_ff + 3'd1) < {1'b0, status.pos}) begin
                  idx_in = idx_ff + 3'd1;
               end else begin
                  state_in = after_state;
                  idx_in   = after_idx;
               end
            end
         end
         S_TAIL4: begin
            if (item_done) begin
               if (status.cnt > 4'd4) begin
                  state_in = S_TAIL1;
                  idx_in   = 3'd4;
               end else begin
                  state_in = S_AVAL;
               end
            end
         end
         S_TAIL1: begin
            if (item_done) begin
               if (({1'b0, idx_ff} + 4'd1) < status.cnt) begin
                  idx_in = idx_ff + 3'd1;
               end else begin
                  state_in = S_AVAL;
               end
            end
         end
         S_AVAL: begin
            if (item_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register valid: held until the sink takes the transfer
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= 2'd0;
         wr_ff        <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         wr_ff        <= wr_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // byte steps never run past the tail byte count
   a_tail1_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAIL1) |-> (({1'b0, idx_ff}) < status.cnt))
      else $error("byte step index beyond tail count");

   // 8-byte steps read only buffered words or the current word
   a_tail8_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAIL8) |-> ((idx_ff == 3'd3) || (idx_ff < {1'b0, status.pos})))
      else $error("8-byte step reads an unwritten buffer entry");

   // a last word closes the input until its hash is out
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && status.in_last) |=> !req_ready)
      else $error("input taken while a message is finishing");

   // finalising loads the result register and returns to idle
   a_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("hash not presented after finalise");

endmodule

`default_nettype wire

// ===== sv/xxhash64_stream_hasher.sv =====
// ============================================================================
// xxhash64_stream_hasher: streaming XXH64 of one message per result
// Words enter on req_ch (valid/ready), the hash leaves on rsp_ch and the
// seed is written on csr_ch, which is always ready.
//
// Usage:
//   A message is a run of little-endian 64-bit words ending with last set;
//   byte_count (0 to 8, larger reads as 8) counts only on the last word.
//   One hash_value is returned per message; the seed in force when the
//   first word is taken applies to the whole message.
// Sequence:
//   Words that fill the stripe buffer are taken without a stall. The word
//   completing a 32-byte stripe runs eight multiplies on the single
//   two-stage 64-bit multiplier. The last word adds the finish: lane merge
//   when a stripe was seen (else the short-key step), the length step, three
//   multiplies per 8-byte tail word, two for a 4-byte step, two per single
//   byte, two of avalanche and the load of the result register.
// Reset clears the message state and the seed to zero; no hash is pending.
// A stalled receiver holds the result register; words of the next message
// are still taken, and its finish waits until the register is free.
// ============================================================================
`default_nettype none

module xxhash64_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   xxh64_req_if.sink   req_ch,
   xxh64_rsp_if.source rsp_ch,
   xxh64_csr_if.sink   csr_ch
);
   import xxh64_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // seed writes are taken at once
   assign csr_ch.ready = 1'b1;

   xxh64_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   xxh64_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .in_data_word  (req_ch.data_word),
      .in_byte_count (req_ch.byte_count),
      .in_last       (req_ch.last),
      .seed_we       (csr_ch.valid),
      .seed_data     (csr_ch.hash_seed),
      .hash_value    (rsp_ch.hash_value)
   );

endmodule

`default_nettype wire
